@@ hw/rtl/r2k_pkg.sv @@
// Package for the romaji-to-kana stream converter: result types, the fixed
// romaji key tables and the per-position decision function.
// Used by romaji_to_kana_stream; no other dependencies.
package r2k_pkg;

	localparam logic [15:0] KANA_LO    = 16'h3041;
	localparam logic [15:0] KANA_HI    = 16'h3096;
	localparam logic [15:0] KATA_SHIFT = 16'h0060;
	localparam logic [15:0] KANA_NN    = 16'h3093;
	localparam logic [15:0] KANA_TSU   = 16'h3063;
	localparam int          MAX_RES    = 4;

	typedef struct packed {
		logic        hit;
		logic [15:0] u0;
		logic [15:0] u1;
	} match_t;

	typedef struct packed {
		logic        stop;
		logic [1:0]  len;
		logic [15:0] u0;
		logic [15:0] u1;
	} dec_t;

	typedef struct packed {
		logic [15:0] code;
		logic        left;
		logic        last;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] e;
		logic [2:0]         n;
	} list_t;

	function automatic match_t hit2(input logic [15:0] a, input logic [15:0] b);
		match_t r;
		r.hit = 1'b1;
		r.u0 = a;
		r.u1 = b;
		return r;
	endfunction

	function automatic match_t match3(input logic [23:0] k);
		match_t r;
		r = '0;
		case (k)
			"kya": r = hit2(16'h304D, 16'h3083);
			"kyu": r = hit2(16'h304D, 16'h3085);
			"kyo": r = hit2(16'h304D, 16'h3087);
			"gya": r = hit2(16'h304E, 16'h3083);
			"gyu": r = hit2(16'h304E, 16'h3085);
			"gyo": r = hit2(16'h304E, 16'h3087);
			"sha": r = hit2(16'h3057, 16'h3083);
			"shu": r = hit2(16'h3057, 16'h3085);
			"sho": r = hit2(16'h3057, 16'h3087);
			"sya": r = hit2(16'h3057, 16'h3083);
			"syu": r = hit2(16'h3057, 16'h3085);
			"syo": r = hit2(16'h3057, 16'h3087);
			"jya": r = hit2(16'h3058, 16'h3083);
			"jyu": r = hit2(16'h3058, 16'h3085);
			"jyo": r = hit2(16'h3058, 16'h3087);
			"cha": r = hit2(16'h3061, 16'h3083);
			"chu": r = hit2(16'h3061, 16'h3085);
			"cho": r = hit2(16'h3061, 16'h3087);
			"tya": r = hit2(16'h3061, 16'h3083);
			"tyu": r = hit2(16'h3061, 16'h3085);
			"tyo": r = hit2(16'h3061, 16'h3087);
			"nya": r = hit2(16'h306B, 16'h3083);
			"nyu": r = hit2(16'h306B, 16'h3085);
			"nyo": r = hit2(16'h306B, 16'h3087);
			"hya": r = hit2(16'h3072, 16'h3083);
			"hyu": r = hit2(16'h3072, 16'h3085);
			"hyo": r = hit2(16'h3072, 16'h3087);
			"bya": r = hit2(16'h3073, 16'h3083);
			"byu": r = hit2(16'h3073, 16'h3085);
			"byo": r = hit2(16'h3073, 16'h3087);
			"pya": r = hit2(16'h3074, 16'h3083);
			"pyu": r = hit2(16'h3074, 16'h3085);
			"pyo": r = hit2(16'h3074, 16'h3087);
			"mya": r = hit2(16'h307F, 16'h3083);
			"myu": r = hit2(16'h307F, 16'h3085);
			"myo": r = hit2(16'h307F, 16'h3087);
			"rya": r = hit2(16'h308A, 16'h3083);
			"ryu": r = hit2(16'h308A, 16'h3085);
			"ryo": r = hit2(16'h308A, 16'h3087);
			"shi": r = hit2(16'h3057, 16'h0000);
			"chi": r = hit2(16'h3061, 16'h0000);
			"tsu": r = hit2(16'h3064, 16'h0000);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic match_t match2(input logic [15:0] k);
		match_t r;
		r = '0;
		case (k)
			"ja": r = hit2(16'h3058, 16'h3083);
			"ju": r = hit2(16'h3058, 16'h3085);
			"jo": r = hit2(16'h3058, 16'h3087);
			"ka": r = hit2(16'h304B, 16'h0000);
			"ki": r = hit2(16'h304D, 16'h0000);
			"ku": r = hit2(16'h304F, 16'h0000);
			"ke": r = hit2(16'h3051, 16'h0000);
			"ko": r = hit2(16'h3053, 16'h0000);
			"ga": r = hit2(16'h304C, 16'h0000);
			"gi": r = hit2(16'h304E, 16'h0000);
			"gu": r = hit2(16'h3050, 16'h0000);
			"ge": r = hit2(16'h3052, 16'h0000);
			"go": r = hit2(16'h3054, 16'h0000);
			"sa": r = hit2(16'h3055, 16'h0000);
			"si": r = hit2(16'h3057, 16'h0000);
			"su": r = hit2(16'h3059, 16'h0000);
			"se": r = hit2(16'h305B, 16'h0000);
			"so": r = hit2(16'h305D, 16'h0000);
			"za": r = hit2(16'h3056, 16'h0000);
			"ji": r = hit2(16'h3058, 16'h0000);
			"zi": r = hit2(16'h3058, 16'h0000);
			"zu": r = hit2(16'h305A, 16'h0000);
			"ze": r = hit2(16'h305C, 16'h0000);
			"zo": r = hit2(16'h305E, 16'h0000);
			"ta": r = hit2(16'h305F, 16'h0000);
			"ti": r = hit2(16'h3061, 16'h0000);
			"tu": r = hit2(16'h3064, 16'h0000);
			"te": r = hit2(16'h3066, 16'h0000);
			"to": r = hit2(16'h3068, 16'h0000);
			"da": r = hit2(16'h3060, 16'h0000);
			"di": r = hit2(16'h3062, 16'h0000);
			"du": r = hit2(16'h3065, 16'h0000);
			"de": r = hit2(16'h3067, 16'h0000);
			"do": r = hit2(16'h3069, 16'h0000);
			"na": r = hit2(16'h306A, 16'h0000);
			"ni": r = hit2(16'h306B, 16'h0000);
			"nu": r = hit2(16'h306C, 16'h0000);
			"ne": r = hit2(16'h306D, 16'h0000);
			"no": r = hit2(16'h306E, 16'h0000);
			"ha": r = hit2(16'h306F, 16'h0000);
			"hi": r = hit2(16'h3072, 16'h0000);
			"fu": r = hit2(16'h3075, 16'h0000);
			"hu": r = hit2(16'h3075, 16'h0000);
			"he": r = hit2(16'h3078, 16'h0000);
			"ho": r = hit2(16'h307B, 16'h0000);
			"ba": r = hit2(16'h3070, 16'h0000);
			"bi": r = hit2(16'h3073, 16'h0000);
			"bu": r = hit2(16'h3076, 16'h0000);
			"be": r = hit2(16'h3079, 16'h0000);
			"bo": r = hit2(16'h307C, 16'h0000);
			"pa": r = hit2(16'h3071, 16'h0000);
			"pi": r = hit2(16'h3074, 16'h0000);
			"pu": r = hit2(16'h3077, 16'h0000);
			"pe": r = hit2(16'h307A, 16'h0000);
			"po": r = hit2(16'h307D, 16'h0000);
			"ma": r = hit2(16'h307E, 16'h0000);
			"mi": r = hit2(16'h307F, 16'h0000);
			"mu": r = hit2(16'h3080, 16'h0000);
			"me": r = hit2(16'h3081, 16'h0000);
			"mo": r = hit2(16'h3082, 16'h0000);
			"ya": r = hit2(16'h3084, 16'h0000);
			"yu": r = hit2(16'h3086, 16'h0000);
			"yo": r = hit2(16'h3088, 16'h0000);
			"ra": r = hit2(16'h3089, 16'h0000);
			"ri": r = hit2(16'h308A, 16'h0000);
			"ru": r = hit2(16'h308B, 16'h0000);
			"re": r = hit2(16'h308C, 16'h0000);
			"ro": r = hit2(16'h308D, 16'h0000);
			"wa": r = hit2(16'h308F, 16'h0000);
			"wo": r = hit2(16'h3092, 16'h0000);
			"nn": r = hit2(16'h3093, 16'h0000);
			"n'": r = hit2(16'h3093, 16'h0000);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic match_t match1(input logic [7:0] k);
		match_t r;
		r = '0;
		case (k)
			"a": r = hit2(16'h3042, 16'h0000);
			"i": r = hit2(16'h3044, 16'h0000);
			"u": r = hit2(16'h3046, 16'h0000);
			"e": r = hit2(16'h3048, 16'h0000);
			"o": r = hit2(16'h304A, 16'h0000);
			"-": r = hit2(16'h30FC, 16'h0000);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic is_vowel(input logic [6:0] c);
		return c == 7'("a") || c == 7'("i") || c == 7'("u") || c == 7'("e") || c == 7'("o");
	endfunction

	// One decision at the head of a window of m valid characters (1 to 3).
	function automatic dec_t decide(input logic [6:0] w0, input logic [6:0] w1,
			input logic [6:0] w2, input logic [1:0] m);
		dec_t   d;
		match_t r3;
		match_t r2;
		match_t r1;
		logic   nx_soft;
		logic   cons;
		r3 = match3({1'b0, w0, 1'b0, w1, 1'b0, w2});
		r2 = match2({1'b0, w0, 1'b0, w1});
		r1 = match1({1'b0, w0});
		nx_soft = is_vowel(w1) || w1 == 7'("y") || w1 == 7'("n") || w1 == 7'("'");
		cons = w0 >= 7'("a") && w0 <= 7'("z") && !is_vowel(w0);
		d = '0;
		if (w0 == 7'("n") && m == 2'd1) begin
			d.stop = 1'b1;
		end else if (w0 == 7'("n") && m >= 2'd2 && !nx_soft) begin
			d.len = 2'd1;
			d.u0 = KANA_NN;
		end else if (m >= 2'd2 && w1 == w0 && cons && w0 != 7'("n")) begin
			d.len = 2'd1;
			d.u0 = KANA_TSU;
		end else if (m == 2'd3 && r3.hit) begin
			d.len = 2'd3;
			d.u0 = r3.u0;
			d.u1 = r3.u1;
		end else if (m >= 2'd2 && r2.hit) begin
			d.len = 2'd2;
			d.u0 = r2.u0;
			d.u1 = r2.u1;
		end else if (m >= 2'd1 && r1.hit) begin
			d.len = 2'd1;
			d.u0 = r1.u0;
		end else begin
			d.stop = 1'b1;
		end
		return d;
	endfunction

	// Appends one result if the list is not full; kana in the hiragana range moves to katakana in that mode.
	function automatic list_t push(input list_t l, input logic [15:0] code,
			input logic left, input logic kata);
		list_t       r;
		logic [15:0] c;
		r = l;
		c = code;
		if (!left && kata && code >= KANA_LO && code <= KANA_HI)
			c = code + KATA_SHIFT;
		if (l.n < 3'(MAX_RES)) begin
			r.e[l.n[1:0]].code = c;
			r.e[l.n[1:0]].left = left;
			r.e[l.n[1:0]].last = 1'b0;
			r.n = l.n + 3'd1;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/romaji_to_kana_stream.sv @@
// Streaming romaji-to-kana converter, top level.
// Depends on r2k_pkg for the key tables, the decision function and result types.
//
//   channel   signals                                   direction
//   in        in_valid, in_ready, char_code, is_last    into the block
//   out       out_valid, out_ready, code_unit,
//             is_leftover, last_of_string               out of the block
//   cfg       cfg_valid, cfg_ready, cfg_data            into the block
//
// An accepted character waits in the input register; then all decisions it causes
// are taken in one pass and its results (up to four) go to a result list. The list
// drains one result per cycle while out_ready is high, so the input takes one
// character per cycle while each has at most one result; more results stall the input.
// Reset clears the buffer count, the stop flag, the mode and both handshakes.
// A stalled output holds the list; the input register waits until the list frees.
module romaji_to_kana_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  char_code,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        is_leftover,
	output logic        last_of_string,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import r2k_pkg::*;

	logic               valid_s1;
	logic [6:0]         char_s1;
	logic               last_s1;
	logic               mode_q;
	logic [6:0]         buf_q [3];
	logic [1:0]         cnt_q;
	logic               stopped_q;
	res_t [MAX_RES-1:0] res_e_q;
	logic [2:0]         res_n_q;
	logic [2:0]         rd_q;

	logic        adv;
	logic        list_free;
	logic [6:0]  c_fold;
	logic [6:0]  bufn [3];
	logic [1:0]  cntn;
	dec_t        d [3];
	dec_t        dk;
	logic [2:0]  p;
	logic [2:0]  rem;
	logic [2:0]  idx;
	logic        st;
	list_t       lst;
	logic [6:0]  buf_d [3];
	logic [1:0]  cnt_d;
	logic        stop_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// The list frees when it is empty or its last result leaves in this cycle.
	assign list_free = (rd_q == res_n_q) || (rd_q + 3'd1 == res_n_q && out_ready);
	assign adv = valid_s1 && list_free;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	always_comb begin
		c_fold = char_s1;
		if (char_s1 >= 7'("A") && char_s1 <= 7'("Z"))
			c_fold = char_s1 + 7'd32;
		bufn = buf_q;
		if (cnt_q != 2'd3)
			bufn[cnt_q] = c_fold;
		cntn = cnt_q + 2'd1;
		d[0] = decide(bufn[0], bufn[1], bufn[2], cntn);
		d[1] = decide(bufn[1], bufn[2], 7'd0, cntn - 2'd1);
		d[2] = decide(bufn[2], 7'd0, 7'd0, cntn - 2'd2);

		lst = '0;
		p = 3'd0;
		st = 1'b0;
		rem = 3'd0;
		idx = 3'd0;
		dk = '0;
		if (stopped_q) begin
			lst = push(lst, {9'd0, c_fold}, 1'b1, mode_q);
			st = 1'b1;
		end else begin
			// Up to three decisions, each at the window that the one before left.
			for (int it = 0; it < 3; it++) begin
				rem = {1'b0, cntn} - p;
				if (rem != 3'd0 && !st && (rem == 3'd3 || last_s1)) begin
					dk = d[p[1:0]];
					if (dk.stop) begin
						for (int j = 0; j < 3; j++) begin
							idx = p + 3'(j);
							if (idx < {1'b0, cntn})
								lst = push(lst, {9'd0, bufn[idx[1:0]]}, 1'b1, mode_q);
						end
						st = 1'b1;
					end else begin
						lst = push(lst, dk.u0, 1'b0, mode_q);
						if (dk.u1 != 16'd0)
							lst = push(lst, dk.u1, 1'b0, mode_q);
						p = p + {1'b0, dk.len};
					end
				end
			end
		end

		if (last_s1 && lst.n != 3'd0)
			lst.e[lst.n[1:0] - 2'd1].last = 1'b1;

		for (int i = 0; i < 3; i++) begin
			idx = p + 3'(i);
			buf_d[i] = (idx < 3'd3) ? bufn[idx[1:0]] : 7'd0;
		end
		if (last_s1 || st)
			cnt_d = 2'd0;
		else
			cnt_d = 2'({1'b0, cntn} - p);
		stop_d = st && !last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			stopped_q <= 1'b0;
		end else if (adv) begin
			cnt_q <= cnt_d;
			stopped_q <= stop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			buf_q <= buf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_n_q <= 3'd0;
			rd_q <= 3'd0;
		end else if (adv) begin
			res_n_q <= lst.n;
			rd_q <= 3'd0;
		end else if (out_valid && out_ready) begin
			rd_q <= rd_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_e_q <= lst.e;
	end

	assign out_valid      = rd_q < res_n_q;
	assign code_unit      = res_e_q[rd_q[1:0]].code;
	assign is_leftover    = res_e_q[rd_q[1:0]].left;
	assign last_of_string = res_e_q[rd_q[1:0]].last;

	// Between characters the buffer never stays full.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("lookahead buffer left full between characters");

	// Once stopped, nothing waits in the buffer.
	assert property (@(posedge clk) disable iff (!arst_n) stopped_q |-> cnt_q == 2'd0)
		else $error("characters buffered while conversion is stopped");

	// A final character always leaves at least one result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (res_n_q != 3'd0 && out_valid))
		else $error("final character produced no result");

	// The read pointer never passes the list length.
	assert property (@(posedge clk) disable iff (!arst_n) rd_q <= res_n_q)
		else $error("result read pointer past list end");

endmodule
